/* hdl/assert_macros.svh */
// Assertion macros shared by the RTL of the deque block.
// Relies on clk and arst_n being visible in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define DEQ_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define DEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/deq_pkg.sv */
// Types and constants for the deque block.
// No dependencies.
package deq_pkg;

	localparam int VALUE_W = 32;
	localparam int KIND_W  = 3;
	localparam int COUNT_W = 11;

	typedef logic signed [VALUE_W-1:0] value_t;
	typedef logic [KIND_W-1:0]         kind_t;
	typedef logic [COUNT_W-1:0]        count_t;

	localparam kind_t KIND_PUSH_FRONT = 3'd0;
	localparam kind_t KIND_PUSH_BACK  = 3'd1;
	localparam kind_t KIND_POP_FRONT  = 3'd2;
	localparam kind_t KIND_POP_BACK   = 3'd3;
	localparam kind_t KIND_QUERY      = 3'd4;

	localparam value_t NEG_ONE = -32'sd1;

endpackage

/* hdl/double_ended_queue_core.sv */
// Double-ended queue of signed 32-bit values in a ring memory of DEPTH entries.
// Depends on deq_pkg and assert_macros.svh.
//
//  channel  | handshake          | fields
//  ---------+--------------------+--------------------------------------------
//  request  | start / busy       | kind, value
//  result   | done (one cycle)   | popped, pop_empty, front_value, back_value,
//           |                    | count, is_empty, overflow
//
// For each request, the ring memory is written or read at the accept
// edge, and the registered read data refreshes the cached front/back value
// on the next edge, when the result is registered. done is high for one
// cycle and busy is low in that cycle, so a new request may be accepted
// while the result is shown. No clearing pass after reset; the memory is
// only read at occupied slots. The result side cannot stall.

`include "assert_macros.svh"

module double_ended_queue_core #(
	parameter int DEPTH = 1024
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  deq_pkg::kind_t  kind,
	input  deq_pkg::value_t value,
	output logic            done,
	output deq_pkg::value_t popped,
	output logic            pop_empty,
	output deq_pkg::value_t front_value,
	output deq_pkg::value_t back_value,
	output deq_pkg::count_t count,
	output logic            is_empty,
	output logic            overflow
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 1;

	// ring storage
	deq_pkg::value_t mem [DEPTH];
	deq_pkg::value_t rd_data_s1;

	// control state
	logic [AW-1:0] head_q;
	logic [CW-1:0] occ_q;
	logic          pend_s1;
	logic          done_q;

	// cached end values
	deq_pkg::value_t front_q;
	deq_pkg::value_t back_q;

	// per-request stage
	logic            reload_front_s1;
	logic            reload_back_s1;
	deq_pkg::value_t popped_s1;
	logic            pop_empty_s1;
	logic            overflow_s1;

	// result registers
	deq_pkg::value_t popped_q;
	logic            pop_empty_q;
	deq_pkg::value_t front_value_q;
	deq_pkg::value_t back_value_q;
	deq_pkg::count_t count_q;
	logic            is_empty_q;
	logic            overflow_q;

	logic          accept;
	logic          full;
	logic          empty;
	logic          many;
	logic [AW-1:0] head_inc;
	logic [AW-1:0] head_dec;
	logic [SW-1:0] sum_tail;
	logic [SW-1:0] sum_back;
	logic [AW-1:0] tail_slot;
	logic [AW-1:0] new_back_slot;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic          is_push_front;
	logic          is_push_back;
	logic          is_pop_front;
	logic          is_pop_back;
	logic [CW+deq_pkg::COUNT_W-1:0] cnt_ext;
	deq_pkg::value_t front_next;
	deq_pkg::value_t back_next;

	assign accept = start && !busy;
	assign busy   = pend_s1;
	assign full   = (occ_q == CW'(DEPTH));
	assign empty  = (occ_q == '0);
	assign many   = (occ_q >= CW'(2));

	always_comb begin
		is_push_front = 1'b0;
		is_push_back  = 1'b0;
		is_pop_front  = 1'b0;
		is_pop_back   = 1'b0;
		unique case (kind)
			deq_pkg::KIND_PUSH_FRONT: is_push_front = 1'b1;
			deq_pkg::KIND_PUSH_BACK:  is_push_back  = 1'b1;
			deq_pkg::KIND_POP_FRONT:  is_pop_front  = 1'b1;
			deq_pkg::KIND_POP_BACK:   is_pop_back   = 1'b1;
			default: ;
		endcase
	end

	// ring arithmetic, single wrap correction since sums stay below 2*DEPTH
	assign head_inc = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
	assign head_dec = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
	assign sum_tail = SW'(head_q) + SW'(occ_q);
	assign sum_back = SW'(head_q) + SW'(occ_q) - SW'(2);
	assign tail_slot = (sum_tail >= SW'(DEPTH)) ? AW'(sum_tail - SW'(DEPTH)) : AW'(sum_tail);
	assign new_back_slot = (sum_back >= SW'(DEPTH)) ? AW'(sum_back - SW'(DEPTH))
		: AW'(sum_back);

	assign wr_en   = accept && !full && (is_push_front || is_push_back);
	assign wr_addr = is_push_front ? head_dec : tail_slot;
	assign rd_en   = accept && many && (is_pop_front || is_pop_back);
	assign rd_addr = is_pop_front ? head_inc : new_back_slot;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= value;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			occ_q   <= '0;
			pend_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			pend_s1 <= accept;
			done_q  <= pend_s1;
			if (accept) begin
				if (is_push_front && !full) begin
					head_q <= head_dec;
					occ_q  <= occ_q + CW'(1);
				end else if (is_push_back && !full) begin
					occ_q  <= occ_q + CW'(1);
				end else if (is_pop_front && !empty) begin
					head_q <= head_inc;
					occ_q  <= occ_q - CW'(1);
				end else if (is_pop_back && !empty) begin
					occ_q  <= occ_q - CW'(1);
				end
			end
		end
	end

	// front/back seen by the result, with the memory read folded in
	assign front_next = reload_front_s1 ? rd_data_s1 : front_q;
	assign back_next  = reload_back_s1 ? rd_data_s1 : back_q;
	assign cnt_ext    = {{deq_pkg::COUNT_W{1'b0}}, occ_q};

	always_ff @(posedge clk) begin
		if (accept) begin
			reload_front_s1 <= is_pop_front && many;
			reload_back_s1  <= is_pop_back && many;
			pop_empty_s1    <= (is_pop_front || is_pop_back) && empty;
			overflow_s1     <= (is_push_front || is_push_back) && full;
			if (is_pop_front && !empty) begin
				popped_s1 <= front_q;
			end else if (is_pop_back && !empty) begin
				popped_s1 <= back_q;
			end else begin
				popped_s1 <= deq_pkg::NEG_ONE;
			end
			if (is_push_front && !full) begin
				front_q <= value;
				if (empty) begin
					back_q <= value;
				end
			end else if (is_push_back && !full) begin
				back_q <= value;
				if (empty) begin
					front_q <= value;
				end
			end
		end
		if (pend_s1) begin
			front_q       <= front_next;
			back_q        <= back_next;
			popped_q      <= popped_s1;
			pop_empty_q   <= pop_empty_s1;
			overflow_q    <= overflow_s1;
			is_empty_q    <= empty;
			count_q       <= cnt_ext[deq_pkg::COUNT_W-1:0];
			front_value_q <= empty ? deq_pkg::NEG_ONE : front_next;
			back_value_q  <= empty ? deq_pkg::NEG_ONE : back_next;
		end
	end

	assign done        = done_q;
	assign popped      = popped_q;
	assign pop_empty   = pop_empty_q;
	assign front_value = front_value_q;
	assign back_value  = back_value_q;
	assign count       = count_q;
	assign is_empty    = is_empty_q;
	assign overflow    = overflow_q;

	`DEQ_ASSERT_NEXT(a_accept_pends, accept, pend_s1, "accepted request not staged")
	`DEQ_ASSERT_NEXT(a_pend_done, pend_s1, done_q && !pend_s1, "staged request gave no result")
	`DEQ_ASSERT_IMPL(a_occ_bound, 1'b1, occ_q <= CW'(DEPTH), "occupancy beyond depth")
	`DEQ_ASSERT_IMPL(a_ovf_full, done_q && overflow_q, occ_q == CW'(DEPTH),
		"overflow flagged while not full")
	`DEQ_ASSERT_IMPL(a_empty_ends, done_q && is_empty_q,
		front_value_q == deq_pkg::NEG_ONE && back_value_q == deq_pkg::NEG_ONE,
		"empty result with stale end values")

endmodule

/* tb/sv/deq_result_checker.sv */
// Result checker for double_ended_queue_core: predicts every accepted request
// and compares each done strobe with the oldest prediction.
// Depends on deq_pkg.
module deq_result_checker #(
	parameter int DEPTH = 1024
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            busy,
	input  deq_pkg::kind_t  kind,
	input  deq_pkg::value_t value,
	input  logic            done,
	input  deq_pkg::value_t popped,
	input  logic            pop_empty,
	input  deq_pkg::value_t front_value,
	input  deq_pkg::value_t back_value,
	input  deq_pkg::count_t count,
	input  logic            is_empty,
	input  logic            overflow,
	output int              mismatches,
	output int              outstanding,
	output int              results_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		deq_pkg::value_t popped;
		logic            pop_empty;
		deq_pkg::value_t front_value;
		deq_pkg::value_t back_value;
		deq_pkg::count_t count;
		logic            is_empty;
		logic            overflow;
	} deq_result_t;

	// shadow deque
	deq_pkg::value_t ring [DEPTH];
	int              ring_head;
	int              ring_level;

	deq_result_t want_q [$];

	function automatic deq_result_t apply_request(input deq_pkg::kind_t op,
			input deq_pkg::value_t din);
		deq_result_t r;
		r.popped    = deq_pkg::NEG_ONE;
		r.pop_empty = 1'b0;
		r.overflow  = 1'b0;
		case (op)
		deq_pkg::KIND_PUSH_FRONT: begin
			if (ring_level >= DEPTH) begin
				r.overflow = 1'b1;
			end else begin
				ring_head = (ring_head + DEPTH - 1) % DEPTH;
				ring[ring_head] = din;
				ring_level++;
			end
		end
		deq_pkg::KIND_PUSH_BACK: begin
			if (ring_level >= DEPTH) begin
				r.overflow = 1'b1;
			end else begin
				ring[(ring_head + ring_level) % DEPTH] = din;
				ring_level++;
			end
		end
		deq_pkg::KIND_POP_FRONT: begin
			if (ring_level == 0) begin
				r.pop_empty = 1'b1;
			end else begin
				r.popped  = ring[ring_head];
				ring_head = (ring_head + 1) % DEPTH;
				ring_level--;
			end
		end
		deq_pkg::KIND_POP_BACK: begin
			if (ring_level == 0) begin
				r.pop_empty = 1'b1;
			end else begin
				r.popped = ring[(ring_head + ring_level - 1) % DEPTH];
				ring_level--;
			end
		end
		default: ;	// query and unused codes leave the state alone
		endcase
		if (ring_level == 0) begin
			r.front_value = deq_pkg::NEG_ONE;
			r.back_value  = deq_pkg::NEG_ONE;
		end else begin
			r.front_value = ring[ring_head];
			r.back_value  = ring[(ring_head + ring_level - 1) % DEPTH];
		end
		r.count    = deq_pkg::count_t'(ring_level);
		r.is_empty = (ring_level == 0);
		return r;
	endfunction

	task automatic check_field(input string fname, input logic [31:0] exp_v,
			input logic [31:0] got_v, inout int n);
		if (got_v !== exp_v) begin
			$display("%0t: %s expected 'h%0h got 'h%0h", $time, fname, exp_v, got_v);
			n++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		deq_result_t want;
		int bad;
		if (!arst_n) begin
			want_q.delete();
			ring_head    = 0;
			ring_level   = 0;
			mismatches   <= 0;
			outstanding  <= 0;
			results_seen <= 0;
		end else begin
			bad = 0;
			if (done) begin
				if (want_q.size() == 0) begin
					$display("%0t: result strobe with no request outstanding", $time);
					bad++;
				end else begin
					want = want_q[0];
					want_q.delete(0);
					check_field("popped", want.popped, popped, bad);
					check_field("pop_empty", want.pop_empty, pop_empty, bad);
					check_field("front_value", want.front_value, front_value, bad);
					check_field("back_value", want.back_value, back_value, bad);
					check_field("count", want.count, count, bad);
					check_field("is_empty", want.is_empty, is_empty, bad);
					check_field("overflow", want.overflow, overflow, bad);
				end
				results_seen <= results_seen + 1;
			end
			if (start && !busy)
				want_q.insert(want_q.size(), apply_request(kind, value));
			mismatches  <= mismatches + bad;
			outstanding <= want_q.size();
		end
	end

endmodule

/* tb/sv/tb_double_ended_queue_core.sv */
// Testbench top for double_ended_queue_core: clock, reset, request stimulus
// and verdict. Depends on deq_pkg, the core and deq_result_checker.
module tb_double_ended_queue_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int             DEPTH       = 1024;
	localparam int             CYCLE_LIMIT = 400000;
	localparam deq_pkg::kind_t KIND_MAX    = '1;

	logic            clk    = 1'b0;
	logic            arst_n = 1'b0;
	logic            start  = 1'b0;
	deq_pkg::kind_t  kind   = deq_pkg::KIND_QUERY;
	deq_pkg::value_t value  = '0;

	logic            busy, done, pop_empty, is_empty, overflow;
	deq_pkg::value_t popped, front_value, back_value;
	deq_pkg::count_t count;

	int mismatches, outstanding, results_seen;
	int cycle_count = 0;
	int idle_pct    = 0;
	int sent        = 0;
	int level_track = 0;
	int level_peak  = 0;
	int overflows   = 0;
	int empty_pops  = 0;

	double_ended_queue_core #(.DEPTH(DEPTH)) u_dut (
		.clk, .arst_n, .start, .busy, .kind, .value, .done, .popped, .pop_empty,
		.front_value, .back_value, .count, .is_empty, .overflow
	);

	deq_result_checker #(.DEPTH(DEPTH)) u_checker (
		.clk, .arst_n, .start, .busy, .kind, .value, .done, .popped, .pop_empty,
		.front_value, .back_value, .count, .is_empty, .overflow,
		.mismatches, .outstanding, .results_seen
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timed out after %0d cycles", cycle_count);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// start stays high across back-to-back requests; dropped only for a gap
	task automatic issue_request(input deq_pkg::kind_t op, input deq_pkg::value_t din);
		int gap;
		gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 6) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		kind  <= op;
		value <= din;
		do @(posedge clk); while (busy);
		sent++;
		case (op)
		deq_pkg::KIND_PUSH_FRONT, deq_pkg::KIND_PUSH_BACK: begin
			if (level_track < DEPTH) level_track++;
			else overflows++;
		end
		deq_pkg::KIND_POP_FRONT, deq_pkg::KIND_POP_BACK: begin
			if (level_track > 0) level_track--;
			else empty_pops++;
		end
		default: ;
		endcase
		if (level_track > level_peak) level_peak = level_track;
	endtask

	function automatic deq_pkg::value_t pick_value();
		case ($urandom_range(15))
		0:       return 32'sh7FFF_FFFF;
		1:       return 32'sh8000_0000;
		2:       return '0;
		3:       return deq_pkg::NEG_ONE;
		default: return deq_pkg::value_t'($urandom());
		endcase
	endfunction

	// push_pct sets the drift of the fill level
	function automatic deq_pkg::kind_t pick_kind(input int push_pct);
		int r;
		r = $urandom_range(99);
		if (r < push_pct)
			return $urandom_range(1) ? deq_pkg::KIND_PUSH_BACK : deq_pkg::KIND_PUSH_FRONT;
		if (r < 96)
			return $urandom_range(1) ? deq_pkg::KIND_POP_BACK : deq_pkg::KIND_POP_FRONT;
		return deq_pkg::kind_t'($urandom_range(deq_pkg::KIND_QUERY, KIND_MAX));
	endfunction

	task automatic next_phase();
		case ($urandom_range(2))
		0:       idle_pct = 0;
		1:       idle_pct = 66;
		default: idle_pct = 26;
		endcase
	endtask

	initial begin
		int n;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty pops, extreme values, both ends, unused codes
		issue_request(deq_pkg::KIND_QUERY, 32'sh1234_5678);
		issue_request(deq_pkg::KIND_POP_FRONT, '0);
		issue_request(deq_pkg::KIND_POP_BACK, deq_pkg::NEG_ONE);
		issue_request(deq_pkg::KIND_PUSH_FRONT, 32'sh7FFF_FFFF);
		issue_request(deq_pkg::KIND_PUSH_BACK, 32'sh8000_0000);
		issue_request(deq_pkg::KIND_PUSH_FRONT, deq_pkg::NEG_ONE);
		issue_request(deq_pkg::KIND_PUSH_BACK, '0);
		issue_request(deq_pkg::KIND_QUERY, '0);
		for (int k = deq_pkg::KIND_QUERY + 1; k <= KIND_MAX; k++)
			issue_request(deq_pkg::kind_t'(k), 32'shAAAA_AAAA);
		issue_request(deq_pkg::KIND_POP_BACK, '0);
		issue_request(deq_pkg::KIND_POP_FRONT, '0);
		issue_request(deq_pkg::KIND_PUSH_BACK, 32'shAAAA_AAAA);
		issue_request(deq_pkg::KIND_PUSH_FRONT, 32'sh5555_5555);
		for (int i = 0; i < 4; i++)
			issue_request(i[0] ? deq_pkg::KIND_POP_BACK : deq_pkg::KIND_POP_FRONT, '0);
		issue_request(deq_pkg::KIND_POP_FRONT, '0);
		issue_request(deq_pkg::KIND_POP_BACK, '0);

		// fill to full, hammer the full state, drain part way, then churn
		n = 0;
		while (level_track < DEPTH) begin
			if (n % 128 == 0) next_phase();
			issue_request(pick_kind(96), pick_value());
			n++;
		end
		idle_pct = 26;
		for (int i = 0; i < 24; i++)
			issue_request(pick_kind(70), pick_value());
		for (int i = 0; i < 300; i++) begin
			if (i % 128 == 0) next_phase();
			issue_request(pick_kind(4), pick_value());
		end
		for (int i = 0; i < 140; i++) begin
			if (i % 64 == 0) next_phase();
			issue_request(pick_kind(45), pick_value());
		end
		start <= 1'b0;

		do @(posedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);

		$display("%0d requests sent, %0d results checked, fill level peaked at %0d",
			sent, results_seen, level_peak);
		$display("%0d pushes refused when full, %0d pops on an empty queue",
			overflows, empty_pops);
		if (mismatches == 0 && outstanding == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
